// ===== sv/cdfc_pkg.sv =====
// cdfc_pkg: shared types, constants and the crc_b byte update for the
// character deframer with crc check; no dependencies
package cdfc_pkg;

  localparam int unsigned CDFC_QUEUE_DEPTH = 4;
  localparam int unsigned CDFC_COUNT_W     = 9;
  localparam logic [15:0] CDFC_CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CDFC_CRC_POLY    = 16'h8408;
  localparam logic [3:0]  CDFC_STOP_POS    = 4'd9;
  localparam logic [8:0]  CDFC_MAX_RESET   = 9'd256;

  // result kinds
  localparam logic CDFC_KIND_BYTE = 1'b0;
  localparam logic CDFC_KIND_END  = 1'b1;

  // one classified event between front and back
  typedef struct packed {
    logic                    kind;
    logic [7:0]              data;
    logic [CDFC_COUNT_W-1:0] count;
    logic                    truncated;
  } cdfc_event_t;

  // reflected crc_b over one byte, one bit per step
  function automatic logic [15:0] cdfc_crc_update(input logic [15:0] crc,
                                                  input logic [7:0]  data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CDFC_CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/cdfc_front.sv =====
// cdfc_front: character framing, frame end detection and byte counting;
// emits one classified event per completed byte or non-empty frame end
// depends on cdfc_pkg
module cdfc_front import cdfc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic                    symbol_value_i,
  input  logic [CDFC_COUNT_W-1:0] max_frame_size_i,
  output logic                    push_o,
  output cdfc_event_t             event_o
);

  logic [3:0]              bit_pos_q, bit_pos_d;
  logic [7:0]              shift_q, shift_d;
  logic [CDFC_COUNT_W-1:0] bytes_q, bytes_d;

  logic at_stop, marker, framing, limit, frame_end;

  // end condition priority: marker, then framing error, then size limit
  assign at_stop   = (bit_pos_q == CDFC_STOP_POS);
  assign marker    = at_stop && (shift_q == 8'h00) && !symbol_value_i;
  assign framing   = !marker && (((bit_pos_q == 4'd0) && symbol_value_i) ||
                                 (at_stop && !symbol_value_i));
  assign limit     = !marker && !framing && (bytes_q == max_frame_size_i);
  assign frame_end = marker || framing || limit;

  // next state and event
  always_comb begin
    bit_pos_d = bit_pos_q;
    shift_d   = shift_q;
    bytes_d   = bytes_q;
    push_o    = 1'b0;
    event_o.kind      = CDFC_KIND_BYTE;
    event_o.data      = shift_q;
    event_o.count     = bytes_q + 1'b1;
    event_o.truncated = 1'b0;
    if (accept_i) begin
      if (frame_end) begin
        push_o            = (bytes_q != '0);
        event_o.kind      = CDFC_KIND_END;
        event_o.data      = 8'h00;
        event_o.count     = bytes_q;
        event_o.truncated = framing || limit;
        bit_pos_d = 4'd0;
        shift_d   = 8'h00;
        bytes_d   = '0;
      end else if (!at_stop) begin
        // data bits land lsb first after the start bit
        for (int i = 0; i < 8; i++) begin
          if (bit_pos_q == 4'(i + 1)) begin
            shift_d[i] = symbol_value_i;
          end
        end
        bit_pos_d = bit_pos_q + 4'd1;
      end else begin
        push_o    = 1'b1;
        bytes_d   = bytes_q + 1'b1;
        bit_pos_d = 4'd0;
        shift_d   = 8'h00;
      end
    end
  end

  // framing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_pos_q <= 4'd0;
      shift_q   <= 8'h00;
      bytes_q   <= '0;
    end else begin
      bit_pos_q <= bit_pos_d;
      shift_q   <= shift_d;
      bytes_q   <= bytes_d;
    end
  end

endmodule

// ===== sv/cdfc_queue.sv =====
// cdfc_queue: small event queue between front and back
// depends on cdfc_pkg
module cdfc_queue import cdfc_pkg::*; #(
  parameter int unsigned Depth = CDFC_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  cdfc_event_t push_data_i,
  input  logic        pop_i,
  output cdfc_event_t pop_data_o,
  output logic        empty_o,
  output logic        full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cdfc_event_t         slots_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_push, do_pop;

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == CntW'(Depth));
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = slots_q[rd_ptr_q];

  // slot storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/cdfc_back.sv =====
// cdfc_back: crc_b accumulation, frame check and the registered result
// depends on cdfc_pkg
module cdfc_back import cdfc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    empty_i,
  input  cdfc_event_t             event_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    result_kind_o,
  output logic [7:0]              data_byte_o,
  output logic [CDFC_COUNT_W-1:0] byte_count_o,
  output logic                    truncated_o,
  output logic                    crc_error_o
);

  logic [15:0] crc_q, trail_q;
  logic        valid_q;
  logic        kind_q, trunc_q, crc_err_q;
  logic [7:0]  data_q;
  logic [CDFC_COUNT_W-1:0] count_q;
  logic        crc_bad;

  // take an event when the output slot is free or drains this cycle
  assign pop_o = !empty_i && (!valid_q || !out_stall_i);

  // last two bytes must be the inverted crc, low byte first
  assign crc_bad = (event_i.count > CDFC_COUNT_W'(2)) ? ((~crc_q) != trail_q) : 1'b1;

  // crc and trailing byte window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CDFC_CRC_INIT;
      trail_q <= 16'h0000;
    end else if (pop_o) begin
      if (event_i.kind == CDFC_KIND_END) begin
        crc_q   <= CDFC_CRC_INIT;
        trail_q <= 16'h0000;
      end else begin
        if (event_i.count > CDFC_COUNT_W'(2)) begin
          crc_q <= cdfc_crc_update(crc_q, trail_q[7:0]);
        end
        trail_q <= {event_i.data, trail_q[15:8]};
      end
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q    <= event_i.kind;
      data_q    <= event_i.data;
      count_q   <= event_i.count;
      trunc_q   <= event_i.truncated;
      crc_err_q <= (event_i.kind == CDFC_KIND_END) ? crc_bad : 1'b0;
    end
  end

  assign out_valid_o   = valid_q;
  assign result_kind_o = kind_q;
  assign data_byte_o   = data_q;
  assign byte_count_o  = count_q;
  assign truncated_o   = trunc_q;
  assign crc_error_o   = crc_err_q;

endmodule

// ===== sv/char_deframer_with_crc_check_unit.sv =====
// char_deframer_with_crc_check_unit: one symbol per cycle while the queue is not
// full. The edge that accepts a symbol writes its event into a queue slot; a later
// edge loads it into the output register once that register is free. The event queue lets the
// front keep taking symbols while the output is stalled, until it fills.
// Async active-low reset clears framing, crc state and the queue, and sets
// max_frame_size to 256. depends on cdfc_pkg, cdfc_front, cdfc_queue, cdfc_back
module char_deframer_with_crc_check_unit import cdfc_pkg::*; #(
  parameter int unsigned QueueDepth = CDFC_QUEUE_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CDFC_COUNT_W-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    symbol_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    result_kind_o,
  output logic [7:0]              data_byte_o,
  output logic [CDFC_COUNT_W-1:0] byte_count_o,
  output logic                    truncated_o,
  output logic                    crc_error_o
);

  logic [CDFC_COUNT_W-1:0] max_size_q;
  logic        accept, push, pop, q_empty, q_full;
  cdfc_event_t front_event, back_event;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign accept      = in_valid_i && !q_full;

  // size limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= CDFC_MAX_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_size_q <= cfg_data_i;
    end
  end

  cdfc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .symbol_value_i   (symbol_value_i),
    .max_frame_size_i (max_size_q),
    .push_o           (push),
    .event_o          (front_event)
  );

  cdfc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_event),
    .pop_i       (pop),
    .pop_data_o  (back_event),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  cdfc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .event_i       (back_event),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .data_byte_o   (data_byte_o),
    .byte_count_o  (byte_count_o),
    .truncated_o   (truncated_o),
    .crc_error_o   (crc_error_o)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for char_deframer_with_crc_check_unit, driven one symbol at a time
// predicts byte and frame-end results with its own deframer and crc_b; depends on cdfc_pkg

module tb;
  import cdfc_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned PhaseSymbols = 70;

  // one result as seen on the output ports
  typedef struct packed {
    logic                    kind;
    logic [7:0]              data;
    logic [CDFC_COUNT_W-1:0] count;
    logic                    trunc;
    logic                    crc_err;
  } frame_result_t;

  // predicts deframer results and checks them in order
  class deframer_scoreboard;
    logic [CDFC_COUNT_W-1:0] max_size;
    logic [3:0]              bit_pos;
    logic [7:0]              shift_reg;
    logic [CDFC_COUNT_W-1:0] nbytes;
    logic [15:0]             crc_acc;
    logic [15:0]             last_two;
    frame_result_t           expected_q[$];
    int unsigned             errors;

    function new();
      max_size = CDFC_MAX_RESET;
      errors   = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      bit_pos   = '0;
      shift_reg = '0;
      nbytes    = '0;
      crc_acc   = CDFC_CRC_INIT;
      last_two  = '0;
    endfunction

    // reflected crc_b, one data bit per step
    static function logic [15:0] crc_b_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c  = c >> 1;
        if (fb) c = c ^ CDFC_CRC_POLY;
      end
      return c;
    endfunction

    function void set_limit(input logic [CDFC_COUNT_W-1:0] v);
      max_size = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // append one predicted result
    function void add_expected(input frame_result_t r);
      expected_q = {expected_q, r};
    endfunction

    // one accepted symbol transfer
    function void take_symbol(input logic s);
      frame_result_t r;
      logic          marker;
      logic          framing;
      logic          limit;
      marker  = (bit_pos == CDFC_STOP_POS) && (shift_reg == 8'h00) && !s;
      framing = !marker && (((bit_pos == 4'd0) && s) || ((bit_pos == CDFC_STOP_POS) && !s));
      limit   = !marker && !framing && (nbytes == max_size);

      // frame end, silent when nothing was received
      if (marker || framing || limit) begin
        if (nbytes != 0) begin
          r.kind    = CDFC_KIND_END;
          r.data    = 8'h00;
          r.count   = nbytes;
          r.trunc   = framing || limit;
          r.crc_err = (nbytes <= 2) ? 1'b1 : ((~crc_acc) != last_two);
          add_expected(r);
        end
        clear_frame();
        return;
      end

      // start bit and data bits, lsb first
      if (bit_pos != CDFC_STOP_POS) begin
        if (bit_pos != 4'd0) shift_reg[bit_pos - 4'd1] = s;
        bit_pos = bit_pos + 4'd1;
        return;
      end

      // high stop bit: byte done, crc lags two bytes behind
      if (nbytes >= 2) crc_acc = crc_b_byte(crc_acc, last_two[7:0]);
      last_two  = {shift_reg, last_two[15:8]};
      nbytes    = nbytes + 1'b1;
      r.kind    = CDFC_KIND_BYTE;
      r.data    = shift_reg;
      r.count   = nbytes;
      r.trunc   = 1'b0;
      r.crc_err = 1'b0;
      add_expected(r);
      shift_reg = '0;
      bit_pos   = '0;
    endfunction

    function void compare_field(input string name, input logic [CDFC_COUNT_W-1:0] want,
                                input logic [CDFC_COUNT_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // one accepted result transfer
    function void check_result(input frame_result_t got);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: kind %0h byte %0h count %0d",
               got.kind, got.data, got.count);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("result_kind", want.kind, got.kind);
      compare_field("data_byte", want.data, got.data);
      compare_field("byte_count", want.count, got.count);
      compare_field("truncated", want.trunc, got.trunc);
      compare_field("crc_error", want.crc_err, got.crc_err);
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CDFC_COUNT_W-1:0] cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_symbol = 1'b1;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    result_kind;
  logic [7:0]              data_byte;
  logic [CDFC_COUNT_W-1:0] byte_count;
  logic                    truncated;
  logic                    crc_error;

  deframer_scoreboard sb = new();
  logic        no_idle = 1'b0;
  int unsigned symbols_sent = 0;
  int unsigned cycles = 0;
  int          phase_limits [7] = '{1, 2, 9, 256, 0, 256, 17};

  char_deframer_with_crc_check_unit u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .symbol_value_i (in_symbol),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_kind_o  (result_kind),
    .data_byte_o    (data_byte),
    .byte_count_o   (byte_count),
    .truncated_o    (truncated),
    .crc_error_o    (crc_error)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: check accepted transfers, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result('{result_kind, data_byte, byte_count, truncated, crc_error});
    end
    out_stall <= !no_idle && ($urandom_range(99) < 25);
  end

  // one symbol transfer, with random idle cycles ahead of it
  task automatic send_symbol(input logic s);
    while (!no_idle && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_symbol <= s;
    do @(posedge clk); while (in_stall);
    sb.take_symbol(s);
  endtask

  // one 10-etu character
  task automatic send_char(input logic [7:0] b, input logic start_bit, input logic stop_bit);
    send_symbol(start_bit);
    for (int i = 0; i < 8; i++) send_symbol(b[i]);
    send_symbol(stop_bit);
    symbols_sent += 10;
  endtask

  // hold the sender until all results are in, then write max_frame_size
  task automatic write_limit(input logic [CDFC_COUNT_W-1:0] v);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_limit(v);
  endtask

  // random frame: mostly well formed, some broken, over limit or noise
  task automatic send_random_frame(input int lim);
    int          pick;
    int          n;
    logic [15:0] crc;
    logic [15:0] fcs;
    logic [7:0]  b;
    pick = $urandom_range(99);
    // guard time between frames
    repeat ($urandom_range(3)) send_symbol(1'b1);
    if (pick < 60) begin
      n   = ($urandom_range(99) < 90) ? $urandom_range(6, 0) : $urandom_range(14, 7);
      crc = CDFC_CRC_INIT;
      repeat (n) begin
        b   = 8'($urandom);
        crc = deframer_scoreboard::crc_b_byte(crc, b);
        send_char(b, 1'b0, 1'b1);
      end
      fcs = ~crc;
      if ($urandom_range(4) == 0) fcs = fcs ^ (16'h0001 << $urandom_range(15));
      send_char(fcs[7:0], 1'b0, 1'b1);
      send_char(fcs[15:8], 1'b0, 1'b1);
      send_char(8'h00, 1'b0, 1'b0);
    end else if (pick < 75) begin
      repeat ($urandom_range(5, 1)) send_char(8'($urandom), 1'b0, 1'b1);
      if ($urandom_range(1) == 1) begin
        send_symbol(1'b1);
        symbols_sent++;
      end else begin
        b = 8'($urandom_range(255, 1));
        send_char(b, 1'b0, 1'b0);
      end
    end else if (pick < 90 && lim <= 40) begin
      repeat (lim + 1) send_char(8'($urandom), 1'b0, 1'b1);
    end else begin
      repeat ($urandom_range(40, 10)) begin
        send_symbol(1'($urandom_range(1)));
        symbols_sent++;
      end
    end
  endtask

  initial begin
    int          lim;
    int unsigned phase_start;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_limit(CDFC_MAX_RESET);

    // directed: idle high, zero byte, low stop, empty marker, high start after a byte
    send_symbol(1'b1);
    send_char(8'h00, 1'b0, 1'b1);
    send_char(8'hFF, 1'b0, 1'b0);
    send_char(8'h00, 1'b0, 1'b0);
    send_char(8'hA5, 1'b0, 1'b1);
    send_symbol(1'b1);

    // random phases over several frame size limits
    for (int p = 0; p < 7; p++) begin
      lim = (phase_limits[p] != 0) ? phase_limits[p] : $urandom_range(40, 3);
      write_limit(CDFC_COUNT_W'(lim));
      no_idle = (p == 5);
      phase_start = symbols_sent;
      while (symbols_sent - phase_start < PhaseSymbols) send_random_frame(lim);
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
